/* hw/rtl/lzd_pkg.sv */
// Package for the LZ copy/literal stream decoder.
// Holds payload structs, command queue entry, phase and status codes.
// No dependencies.
package lzd_pkg;

  localparam int unsigned HistoryDepthDflt = 65536;
  localparam int unsigned MaxCopyLenDflt   = 64;
  localparam int unsigned QueueDepthDflt   = 4;
  // offset field wide enough for the largest history depth (2^20)
  localparam int unsigned OffW  = 21;
  localparam int unsigned LenW  = 7;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HEADER_BAD   = 3'd1,
    ST_MALFORMED    = 3'd2,
    ST_OVERRUN      = 3'd3,
    ST_INSUFFICIENT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OPCODE,
    PH_LITLEN,
    PH_LITDATA,
    PH_LITSKIP,
    PH_OFFSET,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_EMPTY
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CRD,
    BK_CWR
  } back_state_e;

  typedef enum logic [1:0] {
    TAG_LIT  = 2'd0,
    TAG_OFF1 = 2'd1,
    TAG_OFF2 = 2'd2,
    TAG_OFF4 = 2'd3
  } tag_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        stream_done;
    logic [2:0]  status;
    logic [31:0] produced_count;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       lit;
    logic [OffW-1:0]  offset;
    logic [LenW-1:0]  len;
    logic             done;
    logic [2:0]       status;
  } cmd_t;

  // number of extra bytes following an opcode (literal length or offset)
  function automatic logic [2:0] field_total(input logic [7:0] opc);
    logic [2:0] t;
    unique case (tag_e'(opc[1:0]))
      TAG_LIT:  t = 3'(opc[7:2] - 6'd59);
      TAG_OFF1: t = 3'd1;
      TAG_OFF2: t = 3'd2;
      TAG_OFF4: t = 3'd4;
      default:  t = 3'd0;
    endcase
    return t;
  endfunction

endpackage

/* hw/rtl/lz_copy_literal_stream_decoder_top.sv */
// Top level of the LZ copy/literal stream decoder.
// Depends on lzd_pkg, lzd_front, lzd_queue, lzd_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one compressed
//   byte per request, stream_last on the final byte. The front end parses the
//   length header and commands as each byte is accepted and queues at most one
//   command per byte. Output channel (out_valid_o / out_stall_i / out_item_o)
//   gives one request per decompressed byte, plus one status-only request
//   when a stream ends without a byte on its last input.
//   A literal byte is written and emitted as its command leaves the queue; a
//   copy takes its command, then per copied byte reads the history (BK_CRD)
//   and then writes and emits it (BK_CWR). The front keeps parsing while the
//   queue has room, so input stalls only when the command queue fills. An
//   accepted literal byte enters the queue, then the output register.
//   Reset clears parser, queue and output state; history contents are left
//   as they are and are never read before being written. A stalled receiver
//   holds the output register; the back end waits, the queue fills, then the
//   input is stalled. output_capacity is written via cfg_we_i / cfg_wdata_i;
//   the user must write it only while idle; the block does not enforce this.
module lz_copy_literal_stream_decoder_top #(
  parameter int unsigned HistoryDepth = lzd_pkg::HistoryDepthDflt,
  parameter int unsigned QueueDepth   = lzd_pkg::QueueDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lzd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzd_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);
  import lzd_pkg::*;

  logic [31:0] capacity_q;
  logic        q_full, q_empty, push, pop, accept;
  cmd_t        push_cmd, head_cmd;

  // configuration: output capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // hold input while the command queue is full
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  lzd_front #(.HistoryDepth(HistoryDepth)) u_front (
    .clk_i, .rst_ni,
    .accept_i   (accept),
    .item_i     (in_item_i),
    .capacity_i (capacity_q),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lzd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  lzd_back #(.HistoryDepth(HistoryDepth)) u_back (
    .clk_i, .rst_ni,
    .empty_i     (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/lzd_queue.sv */
// Short command queue between the parser and the executor.
// Depends on lzd_pkg.
module lzd_queue #(
  parameter int unsigned Depth = lzd_pkg::QueueDepthDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lzd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lzd_pkg::cmd_t head_o
);
  import lzd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

/* hw/rtl/lzd_front.sv */
// Front end: header and command parser, range checks, command issue.
// Depends on lzd_pkg.
module lzd_front #(
  parameter int unsigned HistoryDepth = lzd_pkg::HistoryDepthDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  lzd_pkg::in_item_t item_i,
  input  logic [31:0]       capacity_i,
  output logic              push_o,
  output lzd_pkg::cmd_t     cmd_o
);
  import lzd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] exp_q, exp_d;
  logic [5:0]  shift_q, shift_d;
  logic [7:0]  opc_q, opc_d;
  logic [31:0] pend_q, pend_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] prod_q, prod_d;

  logic [7:0]     b;
  logic [1:0]     pos;
  logic [LenW-1:0] clen;
  logic [31:0]    lit_len;
  logic           lit_go;

  assign b = item_i.in_byte;

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    shift_d = shift_q;
    opc_d   = opc_q;
    pend_d  = pend_q;
    left_d  = left_q;
    acc_d   = acc_q;
    err_d   = err_q;
    prod_d  = prod_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: CMD_EMPTY, lit: '0, offset: '0, len: '0, done: 1'b0, status: '0};
    pos     = 2'(field_total(opc_q) - left_q);
    clen    = (tag_e'(opc_q[1:0]) == TAG_OFF1) ? LenW'(opc_q[4:2]) + LenW'(4)
                                               : LenW'(opc_q[7:2]) + LenW'(1);
    lit_len = '0;
    lit_go  = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (shift_q < 6'd32) begin
            exp_d = exp_q | (32'(b[6:0]) << shift_q);
          end
          if (!b[7]) begin
            if (exp_d > capacity_i) begin
              err_d   = ST_INSUFFICIENT;
              phase_d = PH_ERROR;
            end else begin
              phase_d = PH_OPCODE;
            end
          end else begin
            shift_d = shift_q + 6'd7;
            if (shift_d > 6'd32) begin
              err_d   = ST_HEADER_BAD;
              phase_d = PH_ERROR;
            end
          end
        end
        PH_OPCODE: begin
          opc_d = b;
          acc_d = '0;
          if (tag_e'(b[1:0]) == TAG_LIT) begin
            if (b[7:2] >= 6'd60) begin
              left_d  = 3'(b[7:2] - 6'd59);
              phase_d = PH_LITLEN;
            end else begin
              lit_len = 32'(b[7:2]);
              lit_go  = 1'b1;
            end
          end else begin
            if (tag_e'(b[1:0]) == TAG_OFF1) acc_d = {21'b0, b[7:5], 8'b0};
            left_d  = field_total(b);
            phase_d = PH_OFFSET;
          end
        end
        PH_LITLEN, PH_OFFSET: begin
          acc_d  = acc_q | (32'(b) << {pos, 3'b000});
          left_d = left_q - 3'd1;
          if (left_d == 3'd0) begin
            if (phase_q == PH_LITLEN) begin
              lit_len = acc_d;
              lit_go  = 1'b1;
            end else if (acc_d == '0 || acc_d > prod_q || acc_d > 32'(HistoryDepth)) begin
              err_d   = ST_MALFORMED;
              phase_d = PH_ERROR;
            end else if ({1'b0, prod_q} + 33'(clen) > {1'b0, exp_q}) begin
              err_d   = ST_OVERRUN;
              phase_d = PH_ERROR;
            end else begin
              push_o      = 1'b1;
              cmd_o.kind  = CMD_COPY;
              cmd_o.offset = OffW'(acc_d);
              cmd_o.len   = clen;
              prod_d      = prod_q + 32'(clen);
              phase_d     = PH_OPCODE;
            end
          end
        end
        PH_LITDATA: begin
          push_o    = 1'b1;
          cmd_o.kind = CMD_LIT;
          cmd_o.lit = b;
          prod_d    = prod_q + 32'd1;
          if (pend_q == '0) phase_d = PH_OPCODE;
          else pend_d = pend_q - 32'd1;
        end
        PH_LITSKIP: begin
          if (pend_q == '0) begin
            err_d   = ST_OVERRUN;
            phase_d = PH_ERROR;
          end else begin
            pend_d = pend_q - 32'd1;
          end
        end
        PH_ERROR: ;
        default: ;
      endcase

      // literal start: skip the data when it would overrun the header length
      if (lit_go) begin
        pend_d = lit_len;
        if ({2'b0, prod_q} + {2'b0, lit_len} + 34'd1 > {2'b0, exp_q}) phase_d = PH_LITSKIP;
        else phase_d = PH_LITDATA;
      end

      if (item_i.stream_last) begin
        if (phase_d == PH_HEADER) begin
          err_d = ST_HEADER_BAD;
        end else if (phase_d != PH_OPCODE && phase_d != PH_ERROR) begin
          err_d = ST_MALFORMED;
        end
        push_o       = 1'b1;
        cmd_o.done   = 1'b1;
        cmd_o.status = err_d;
        // restart for the next stream
        phase_d = PH_HEADER;
        exp_d   = '0;
        shift_d = '0;
        opc_d   = '0;
        pend_d  = '0;
        left_d  = '0;
        acc_d   = '0;
        err_d   = ST_OK;
        prod_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      exp_q   <= '0;
      shift_q <= '0;
      opc_q   <= '0;
      pend_q  <= '0;
      left_q  <= '0;
      acc_q   <= '0;
      err_q   <= ST_OK;
      prod_q  <= '0;
    end else begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      shift_q <= shift_d;
      opc_q   <= opc_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
      prod_q  <= prod_d;
    end
  end

endmodule

/* hw/rtl/lzd_back.sv */
// Back end: executes literal and copy commands against the history memory.
// Depends on lzd_pkg.
module lzd_back #(
  parameter int unsigned HistoryDepth = lzd_pkg::HistoryDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  lzd_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzd_pkg::out_item_t out_item_o
);
  import lzd_pkg::*;

  localparam int unsigned AddrW = $clog2(HistoryDepth);

  logic [7:0]       hist_mem [HistoryDepth];
  logic [7:0]       rdata_q;
  logic             we;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW:0]   rd_wide;

  back_state_e      state_q, state_d;
  logic [AddrW-1:0] wr_q, wr_d;
  logic [31:0]      prod_q, prod_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [LenW-1:0]  left_q, left_d;
  logic             done_q, done_d;
  logic [2:0]       stat_q, stat_d;
  logic             ovalid_q, ovalid_d;
  out_item_t        oitem_q, oitem_d;
  logic             can_load;
  logic [7:0]       wdata;

  assign can_load = !ovalid_q || !out_stall_i;
  assign rd_wide  = ({1'b0, wr_q} >= (AddrW+1)'(off_q))
                  ? {1'b0, wr_q} - (AddrW+1)'(off_q)
                  : {1'b0, wr_q} + (AddrW+1)'(HistoryDepth) - (AddrW+1)'(off_q);
  assign rd_addr  = rd_wide[AddrW-1:0];

  always_comb begin
    state_d  = state_q;
    wr_d     = wr_q;
    prod_d   = prod_q;
    off_d    = off_q;
    left_d   = left_q;
    done_d   = done_q;
    stat_d   = stat_q;
    ovalid_d = ovalid_q && out_stall_i;
    oitem_d  = oitem_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    wdata    = head_i.lit;

    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i && can_load) begin
          unique case (head_i.kind)
            CMD_LIT: begin
              pop_o    = 1'b1;
              we       = 1'b1;
              wr_d     = (wr_q == AddrW'(HistoryDepth - 1)) ? '0 : wr_q + 1'b1;
              prod_d   = head_i.done ? '0 : prod_q + 32'd1;
              ovalid_d = 1'b1;
              oitem_d  = '{out_byte: head_i.lit, byte_valid: 1'b1,
                           stream_done: head_i.done,
                           status: head_i.done ? head_i.status : ST_OK,
                           produced_count: prod_q + 32'd1, run_last: 1'b1};
            end
            CMD_COPY: begin
              pop_o   = 1'b1;
              off_d   = head_i.offset;
              left_d  = head_i.len;
              done_d  = head_i.done;
              stat_d  = head_i.status;
              state_d = BK_CRD;
            end
            CMD_EMPTY: begin
              pop_o    = 1'b1;
              prod_d   = '0;
              ovalid_d = 1'b1;
              oitem_d  = '{out_byte: 8'd0, byte_valid: 1'b0, stream_done: head_i.done,
                           status: head_i.status, produced_count: prod_q, run_last: 1'b1};
            end
            default: ;
          endcase
        end
      end
      BK_CRD: state_d = BK_CWR;
      BK_CWR: begin
        if (can_load) begin
          we       = 1'b1;
          wdata    = rdata_q;
          wr_d     = (wr_q == AddrW'(HistoryDepth - 1)) ? '0 : wr_q + 1'b1;
          left_d   = left_q - LenW'(1);
          ovalid_d = 1'b1;
          oitem_d  = '{out_byte: rdata_q, byte_valid: 1'b1,
                       stream_done: done_q && (left_d == '0),
                       status: (done_q && (left_d == '0)) ? stat_q : ST_OK,
                       produced_count: prod_q + 32'd1, run_last: (left_d == '0)};
          if (left_d == '0) begin
            prod_d  = done_q ? '0 : prod_q + 32'd1;
            state_d = BK_IDLE;
          end else begin
            prod_d  = prod_q + 32'd1;
            state_d = BK_CRD;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // history: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) hist_mem[wr_q] <= wdata;
    if (state_q == BK_CRD) rdata_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    oitem_q <= oitem_d;
    off_q   <= off_d;
    left_q  <= left_d;
    done_q  <= done_d;
    stat_q  <= stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      wr_q     <= '0;
      prod_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_q     <= wr_d;
      prod_q   <= prod_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_item_o  = oitem_q;

endmodule

/* bench/lz_copy_literal_stream_decoder_top_tb.sv */
// Self-checking bench for the LZ copy/literal stream decoder top level.
// Drives compressed byte streams, predicts every decompressed byte and status.
// Depends on lzd_pkg and lz_copy_literal_stream_decoder_top.
module lz_copy_literal_stream_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lzd_pkg::*;

  localparam int unsigned HistDepth = 65536;
  localparam int unsigned MaxCopy   = 64;
  localparam int unsigned CycleLimit = 2000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  lz_copy_literal_stream_decoder_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_wdata_i
  );

  always #2 clk_i = ~clk_i;

  // Decoder shadow state
  logic [31:0] capacity;
  logic [7:0]  hist_mem [HistDepth];
  logic [31:0] hist_wr;
  logic [31:0] n_produced;
  logic [31:0] exp_len;
  logic [5:0]  hdr_shift;
  phase_e      dec_phase;
  logic [7:0]  opcode;
  logic [31:0] pend_len;
  logic [2:0]  bytes_left;
  logic [31:0] off_acc;
  logic [2:0]  err_code;

  out_item_t   pending_bytes[$];
  out_item_t   step_out[$];
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  bit          noisy_stall = 1'b1;

  function automatic void clear_stream();
    n_produced = '0; exp_len = '0; hdr_shift = '0; dec_phase = PH_HEADER;
    opcode = '0; pend_len = '0; bytes_left = '0; off_acc = '0; err_code = ST_OK;
  endfunction

  function automatic void raise_error(status_e code);
    err_code = code;
    dec_phase = PH_ERROR;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    out_item_t r;
    hist_mem[hist_wr[15:0]] = b;
    hist_wr = (hist_wr + 1) % HistDepth;
    n_produced++;
    r = '0;
    r.out_byte = b; r.byte_valid = 1'b1; r.status = err_code;
    r.produced_count = n_produced;
    step_out.push_back(r);
  endfunction

  function automatic logic [2:0] opc_field_len(logic [7:0] opc);
    if (opc[1:0] == TAG_LIT) return 3'(opc[7:2] - 6'd59);
    if (opc[1:0] == TAG_OFF1) return 3'd1;
    if (opc[1:0] == TAG_OFF2) return 3'd2;
    return 3'd4;
  endfunction

  function automatic void begin_literal(logic [31:0] len_m1);
    pend_len = len_m1;
    if (64'(n_produced) + 64'(len_m1) + 1 > 64'(exp_len)) dec_phase = PH_LITSKIP;
    else dec_phase = PH_LITDATA;
  endfunction

  function automatic void replay_copy();
    logic [31:0] len;
    len = (opcode[1:0] == TAG_OFF1) ? 32'(opcode[4:2]) + 4 : 32'(opcode[7:2]) + 1;
    if (off_acc == 0 || off_acc > n_produced || off_acc > HistDepth) begin
      raise_error(ST_MALFORMED);
      return;
    end
    if (64'(n_produced) + 64'(len) > 64'(exp_len) || len > MaxCopy) begin
      raise_error(ST_OVERRUN);
      return;
    end
    for (int i = 0; i < len; i++)
      emit_byte(hist_mem[(hist_wr + HistDepth - off_acc) % HistDepth]);
    dec_phase = PH_OPCODE;
  endfunction

  // Work out the results of one compressed byte and queue them
  function automatic void decode_byte(logic [7:0] b, logic last);
    logic [2:0] pos;
    out_item_t r;
    step_out.delete();
    case (dec_phase)
      PH_HEADER: begin
        if (hdr_shift < 32) exp_len |= 32'(64'(b[6:0]) << hdr_shift);
        if (!b[7]) begin
          if (exp_len > capacity) raise_error(ST_INSUFFICIENT);
          else dec_phase = PH_OPCODE;
        end else begin
          hdr_shift += 7;
          if (hdr_shift > 32) raise_error(ST_HEADER_BAD);
        end
      end
      PH_OPCODE: begin
        opcode = b; off_acc = '0;
        if (b[1:0] == TAG_LIT) begin
          if (b[7:2] >= 60) begin
            bytes_left = 3'(b[7:2] - 59);
            dec_phase = PH_LITLEN;
          end else begin
            begin_literal(32'(b[7:2]));
          end
        end else begin
          if (b[1:0] == TAG_OFF1) off_acc = 32'(b[7:5]) << 8;
          bytes_left = opc_field_len(b);
          dec_phase = PH_OFFSET;
        end
      end
      PH_LITLEN, PH_OFFSET: begin
        pos = (opc_field_len(opcode) - bytes_left) & 3'd3;
        off_acc |= 32'(b) << (8 * pos);
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          if (dec_phase == PH_LITLEN) begin_literal(off_acc);
          else replay_copy();
        end
      end
      PH_LITDATA: begin
        emit_byte(b);
        if (pend_len == 0) dec_phase = PH_OPCODE;
        else pend_len--;
      end
      PH_LITSKIP: begin
        if (pend_len == 0) raise_error(ST_OVERRUN);
        else pend_len--;
      end
      default: ;
    endcase
    if (last) begin
      if (dec_phase == PH_HEADER) raise_error(ST_HEADER_BAD);
      else if (dec_phase != PH_OPCODE && dec_phase != PH_ERROR) raise_error(ST_MALFORMED);
      if (step_out.size() == 0) begin
        r = '0;
        r.produced_count = n_produced;
        step_out.push_back(r);
      end
      r = step_out.pop_back();
      r.stream_done = 1'b1;
      r.status = err_code;
      step_out.push_back(r);
      clear_stream();
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.run_last = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) pending_bytes.push_back(step_out[i]);
  endfunction

  // Output side: random stall, compare each accepted request
  always @(posedge clk_i) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output request: %p", out_item_o);
        n_errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_item_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_item_o.out_byte);
          n_errors++;
        end
        if (out_item_o.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_item_o.byte_valid);
          n_errors++;
        end
        if (out_item_o.stream_done !== want.stream_done) begin
          $error("stream_done: expected %0b, got %0b", want.stream_done,
                 out_item_o.stream_done);
          n_errors++;
        end
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
          n_errors++;
        end
        if (out_item_o.produced_count !== want.produced_count) begin
          $error("produced_count: expected %0d, got %0d", want.produced_count,
                 out_item_o.produced_count);
          n_errors++;
        end
        if (out_item_o.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_item_o.run_last);
          n_errors++;
        end
      end
    end
    out_stall_i <= noisy_stall && ($urandom_range(99) < 24);
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  bit noisy_send = 1'b1;

  // Hand one request to the block and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic last);
    while (noisy_send && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{in_byte: b, stream_last: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b, last);
  endtask

  task automatic send_stream(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Drop valid, drain every expected result, then allow the pipe to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = v;
    @(posedge clk_i);
  endtask

  // Build a stream of random commands, now and then with a bad offset or broken at the end
  task automatic random_stream(int n_cmds);
    logic [7:0]  s[$];
    int unsigned total;
    int unsigned len, off;
    int unsigned kind;
    total = 0;
    for (int c = 0; c < n_cmds; c++) begin
      kind = (total == 0) ? 0 : $urandom_range(3);
      if (kind == 0) begin
        len = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) begin
          s.push_back({6'd60, TAG_LIT}); s.push_back(8'(len - 1));
        end else begin
          s.push_back({6'(len - 1), TAG_LIT});
        end
        repeat (len) s.push_back(8'($urandom));
        total += len;
      end else begin
        off = $urandom_range(1, total);
        if ($urandom_range(19) == 0) off = $urandom_range(0, 70);
        if (kind == 1 && off < 2048) begin
          len = $urandom_range(4, 11);
          s.push_back({3'(off >> 8), 3'(len - 4), TAG_OFF1}); s.push_back(8'(off));
        end else if (kind == 2) begin
          len = $urandom_range(1, 64);
          s.push_back({6'(len - 1), TAG_OFF2}); s.push_back(8'(off)); s.push_back(8'(off >> 8));
        end else begin
          len = $urandom_range(1, 20);
          s.push_back({6'(len - 1), TAG_OFF4});
          s.push_back(8'(off)); s.push_back(8'(off >> 8));
          s.push_back(8'(off >> 16)); s.push_back(8'(off >> 24));
        end
        total += len;
      end
    end
    send_header_and_body(s, total);
  endtask

  // Header: usually exact, sometimes short so that overrun is hit, sometimes long
  task automatic send_header_and_body(logic [7:0] body[$], int unsigned total);
    logic [7:0] s[$];
    int unsigned v;
    v = ($urandom_range(9) == 0) ? $urandom_range(0, total) : total;
    if ($urandom_range(4) == 0) v = total + $urandom_range(0, 300);
    while (v >= 128) begin
      s.push_back(8'(v | 128));
      v = v >> 7;
    end
    s.push_back(8'(v));
    foreach (body[i]) s.push_back(body[i]);
    // a cut stream now and then
    if ($urandom_range(14) == 0 && s.size() > 2) s = s[0:$urandom_range(0, s.size() - 2)];
    send_stream(s);
  endtask

  typedef struct {
    logic [7:0]  b;
    logic        last;
    logic        checked;
    logic [2:0]  status;
  } vec_t;

  // Directed rows; status is typed only for final requests known by inspection
  vec_t directed[$] = '{
    '{8'h00, 1'b1, 1'b1, ST_OK},          // empty stream, length 0
    '{8'hFF, 1'b1, 1'b1, ST_HEADER_BAD},  // stream ends inside the header
    '{8'hFF, 1'b0, 1'b0, ST_OK},          // five-byte header with top bit on fifth
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_HEADER_BAD},
    '{8'h02, 1'b0, 1'b0, ST_OK},          // length 2: literal of two bytes
    '{8'h04, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b0, ST_OK},
    '{8'h0A, 1'b0, 1'b0, ST_OK},          // length 10: literal, copy of six
    '{8'h04, 1'b0, 1'b0, ST_OK},
    '{8'hA5, 1'b0, 1'b0, ST_OK},
    '{8'h5A, 1'b0, 1'b0, ST_OK},
    '{8'h16, 1'b0, 1'b0, ST_OK},
    '{8'h02, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b0, ST_OK},
    '{8'h05, 1'b0, 1'b0, ST_OK},          // zero offset
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h77, 1'b0, 1'b0, ST_OK},
    '{8'h01, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_MALFORMED},
    '{8'h03, 1'b0, 1'b0, ST_OK},          // truncated literal
    '{8'hF0, 1'b1, 1'b1, ST_MALFORMED}
  };

  initial begin
    out_item_t want;
    clear_stream();
    capacity = 32'hFFFF_FFFF;
    hist_wr = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_byte(directed[i].b, directed[i].last);
      if (directed[i].checked) begin
        want = pending_bytes[$];
        if (want.status !== directed[i].status) begin
          $error("status: expected %0d, got %0d (predictor)", directed[i].status, want.status);
          n_errors++;
        end
      end
    end

    // Small capacity: length 5 against capacity 4
    write_capacity(32'd4);
    send_stream('{8'h05, 8'h00, 8'h11});
    write_capacity(32'd0);
    send_stream('{8'h00});
    send_stream('{8'h01, 8'h00, 8'h3C});
    write_capacity(32'd1000);

    // Random streams: mostly well formed, with some noise
    noisy_stall = 1'b0;
    noisy_send = 1'b0;
    for (int k = 0; k < 24; k++) begin
      if (k == 8) begin
        noisy_stall = 1'b1;
        noisy_send = 1'b1;
      end
      if (k == 14) drain();
      if (k == 16) write_capacity(32'hFFFF_FFFF);
      if ($urandom_range(9) == 0) begin
        logic [7:0] junk[$];
        repeat ($urandom_range(1, 10)) junk.push_back(8'($urandom));
        send_stream(junk);
      end else begin
        random_stream($urandom_range(1, 6));
      end
    end

    drain();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
